// ----- hdl/kls_pkg.sv -----
// Shared types, token codes and byte classification functions for the keyword lexer.
`default_nettype none
package kls_pkg;

	// Default build values.
	localparam int MAX_TEXT_DEF      = 65535;
	localparam int KEYWORD_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH       = 4;
	localparam int KW_WINDOW         = 8;

	// Reset value of the token capacity register.
	localparam logic [15:0] CAP_RESET = 16'd4096;

	// Input item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Token codes.
	localparam logic [4:0] TK_EOF      = 5'd0;
	localparam logic [4:0] TK_WORD     = 5'd1;
	localparam logic [4:0] TK_COMMA    = 5'd3;
	localparam logic [4:0] TK_SEMI     = 5'd4;
	localparam logic [4:0] TK_COLON    = 5'd5;
	localparam logic [4:0] TK_EQUAL    = 5'd6;
	localparam logic [4:0] TK_PLUS     = 5'd7;
	localparam logic [4:0] TK_MINUS    = 5'd8;
	localparam logic [4:0] TK_STAR     = 5'd9;
	localparam logic [4:0] TK_SLASH    = 5'd10;
	localparam logic [4:0] TK_LESS     = 5'd11;
	localparam logic [4:0] TK_GREATER  = 5'd12;
	localparam logic [4:0] TK_LPAREN   = 5'd13;
	localparam logic [4:0] TK_RPAREN   = 5'd14;
	localparam logic [4:0] TK_LBRACE   = 5'd15;
	localparam logic [4:0] TK_RBRACE   = 5'd16;
	localparam logic [4:0] TK_LBRACKET = 5'd17;
	localparam logic [4:0] TK_RBRACKET = 5'd18;
	localparam logic [4:0] TK_LOOP     = 5'd19;
	localparam logic [4:0] TK_BREAK    = 5'd20;
	localparam logic [4:0] TK_CONTINUE = 5'd21;
	localparam logic [4:0] TK_IF       = 5'd22;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	// Characters with a special role.
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_RETURN     = 8'h0D;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	// One token as it leaves the block.
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  status;
	} token_t;

	// One queue record: the tokens caused by one input item.
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
	} rec_t;

	function automatic logic is_text(input logic [7:0] c);
		return c inside {CH_UNDERSCORE, [8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, CH_NEWLINE, CH_RETURN, CH_TAB};
	endfunction

	function automatic logic [4:0] punct_code(input logic [7:0] c);
		logic [4:0] code;
		case (c)
			",": code = TK_COMMA;
			";": code = TK_SEMI;
			":": code = TK_COLON;
			"=": code = TK_EQUAL;
			"+": code = TK_PLUS;
			"-": code = TK_MINUS;
			"*": code = TK_STAR;
			"/": code = TK_SLASH;
			"<": code = TK_LESS;
			">": code = TK_GREATER;
			"(": code = TK_LPAREN;
			")": code = TK_RPAREN;
			"{": code = TK_LBRACE;
			"}": code = TK_RBRACE;
			"[": code = TK_LBRACKET;
			"]": code = TK_RBRACKET;
			default: code = TK_EOF;
		endcase
		return code;
	endfunction

	// Keyword match on the newest bytes of the window; index 0 is the newest.
	function automatic logic [4:0] kw_code(input logic [KW_WINDOW-1:0][7:0] w,
			input logic [15:0] pend);
		logic [4:0] code;
		code = TK_WORD;
		if (pend == 16'd2 && w[1:0] == "if")
			code = TK_IF;
		else if (pend == 16'd4 && w[3:0] == "loop")
			code = TK_LOOP;
		else if (pend == 16'd5 && w[4:0] == "break")
			code = TK_BREAK;
		else if (pend == 16'd8 && w[7:0] == "continue")
			code = TK_CONTINUE;
		return code;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/kls_if.sv -----
// Stream interfaces for the text input channel and the token output channel.
`default_nettype none
interface kls_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, kind, byte_value, input ready);
	modport sink (input valid, kind, byte_value, output ready);
endinterface

interface kls_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [1:0]  status;
	logic        last_of_run;

	modport source (output valid, token_kind, token_start, token_length, status, last_of_run,
		input ready);
	modport sink (input valid, token_kind, token_start, token_length, status, last_of_run,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/kls_front.sv -----
// Front end: accepts text beats, keeps the lexer state and forms token records.
`default_nettype none
module kls_front #(
	parameter int MAX_TEXT      = kls_pkg::MAX_TEXT_DEF,
	parameter int KEYWORD_BYTES = kls_pkg::KEYWORD_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [15:0]  cfg_wr_data,
	kls_in_if.sink            text_in,
	input  wire logic         q_full,
	output logic              q_wr_en,
	output kls_pkg::rec_t     q_wr_data
);
	import kls_pkg::*;

	localparam int POS_W = $clog2(MAX_TEXT + 1);

	logic [7:0]                    held_q;
	logic                          held_vld_q;
	logic [POS_W-1:0]              pos_q;
	logic [15:0]                   pend_q;
	logic [15:0]                   count_q;
	logic [KEYWORD_BYTES-1:0][7:0] win_q;
	logic                          halted_q;
	logic [15:0]                   cap_q;

	logic [7:0]                    held_d;
	logic                          held_vld_d;
	logic [POS_W-1:0]              pos_d;
	logic [15:0]                   pend_d;
	logic [15:0]                   count_d;
	logic [KEYWORD_BYTES-1:0][7:0] win_d;
	logic                          halted_d;

	logic                          accept;
	logic                          at_end;
	logic [15:0]                   pos16;
	logic [15:0]                   pend_inc;
	logic [KEYWORD_BYTES-1:0][7:0] win_sh;
	logic                          word_close;
	logic                          space_close;
	logic [4:0]                    pcode;
	logic                          d_push;
	token_t                        d_tok;
	logic [15:0]                   d_pend_after;
	logic                          full0;
	logic                          full1;
	token_t                        full_tok;
	token_t                        eof_tok;
	rec_t                          rec;
	logic                          rec_push;

	assign text_in.ready = !q_full;
	assign accept        = text_in.valid && !q_full;
	assign at_end        = (text_in.kind == KIND_END);
	assign pos16         = 16'(pos_q);

	// Decision on the held byte, with the incoming beat as lookahead.
	assign pend_inc     = (pend_q == 16'hFFFF) ? pend_q : pend_q + 16'd1;
	assign win_sh       = {win_q[KEYWORD_BYTES-2:0], held_q};
	assign word_close   = is_text(held_q) && (at_end || !is_text(text_in.byte_value));
	assign space_close  = is_space(held_q) && (at_end || !is_space(text_in.byte_value));
	assign pcode        = punct_code(held_q);
	assign d_push       = word_close || (pcode != TK_EOF);
	assign d_pend_after = (d_push || space_close) ? 16'd0 : pend_inc;

	always_comb begin
		d_tok.status = ST_OK;
		d_tok.length = pend_inc;
		if (word_close) begin
			d_tok.kind  = kw_code(win_sh[KW_WINDOW-1:0], pend_inc);
			d_tok.start = pos16 - pend_inc;
		end else begin
			d_tok.kind  = pcode;
			d_tok.start = pos16 - 16'd1;
		end
	end

	// Capacity checks for the first and the second push of one item.
	assign full0    = (count_q >= cap_q);
	assign full1    = ((count_q + 16'd1) >= cap_q);
	assign full_tok = '{kind: TK_EOF, start: 16'd0, length: 16'd0, status: ST_FULL};
	assign eof_tok  = '{kind: TK_EOF, start: pos16, length: 16'd0, status: ST_OK};

	// Next state and the record for the queue.
	always_comb begin
		held_d     = held_q;
		held_vld_d = held_vld_q;
		pos_d      = pos_q;
		pend_d     = pend_q;
		count_d    = count_q;
		win_d      = win_q;
		halted_d   = halted_q;
		rec        = '0;
		rec_push   = 1'b0;
		if (accept) begin
			if (at_end) begin
				if (!halted_q) begin
					rec_push = 1'b1;
					if (held_vld_q && d_push) begin
						if (full0) begin
							rec.tok0 = full_tok;
						end else begin
							rec.tok0 = d_tok;
							rec.tok1 = full1 ? full_tok : eof_tok;
							rec.two  = 1'b1;
						end
					end else if (full0) begin
						rec.tok0 = full_tok;
					end else begin
						rec.tok0        = eof_tok;
						rec.tok0.length = held_vld_q ? d_pend_after : pend_q;
					end
				end
				// The end beat always starts a new text.
				held_d     = '0;
				held_vld_d = 1'b0;
				pos_d      = '0;
				pend_d     = '0;
				count_d    = '0;
				win_d      = '0;
				halted_d   = 1'b0;
			end else if (!halted_q) begin
				if (pos_q >= POS_W'(MAX_TEXT)) begin
					rec_push = 1'b1;
					rec.tok0 = '{kind: TK_EOF, start: pos16, length: 16'd0, status: ST_LONG};
					halted_d = 1'b1;
				end else begin
					held_d     = text_in.byte_value;
					held_vld_d = 1'b1;
					pos_d      = pos_q + POS_W'(1);
					if (held_vld_q) begin
						pend_d = d_pend_after;
						win_d  = win_sh;
						if (d_push) begin
							rec_push = 1'b1;
							if (full0) begin
								rec.tok0   = full_tok;
								halted_d   = 1'b1;
								held_d     = held_q;
								held_vld_d = 1'b0;
								pos_d      = pos_q;
							end else begin
								rec.tok0 = d_tok;
								count_d  = count_q + 16'd1;
							end
						end
					end
				end
			end
		end
	end

	assign q_wr_en   = rec_push;
	assign q_wr_data = rec;

	// Text state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
			pos_q      <= '0;
			pend_q     <= '0;
			count_q    <= '0;
			win_q      <= '0;
			halted_q   <= 1'b0;
		end else begin
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
			pos_q      <= pos_d;
			pend_q     <= pend_d;
			count_q    <= count_d;
			win_q      <= win_d;
			halted_q   <= halted_d;
		end
	end

	// Token capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/kls_queue.sv -----
// Short first-in first-out queue of token records between the front and back ends.
`default_nettype none
module kls_queue #(
	parameter int DEPTH = kls_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  kls_pkg::rec_t      wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output kls_pkg::rec_t      rd_data,
	output logic               empty
);
	import kls_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/kls_back.sv -----
// Back end: takes token records from the queue and sends them out one beat per token.
`default_nettype none
module kls_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  kls_pkg::rec_t q_rd_data,
	input  wire logic     q_empty,
	output logic          q_rd_en,
	kls_out_if.source     token_out
);
	import kls_pkg::*;

	rec_t   rec_q;
	logic   busy_q;
	logic   phase_q;
	logic   fire;
	logic   last_now;
	token_t cur;

	assign last_now = !rec_q.two || phase_q;
	assign fire     = busy_q && token_out.ready;
	assign q_rd_en  = !q_empty && (!busy_q || (fire && last_now));
	assign cur      = phase_q ? rec_q.tok1 : rec_q.tok0;

	// Output beat drawn from the held record.
	assign token_out.valid        = busy_q;
	assign token_out.token_kind   = cur.kind;
	assign token_out.token_start  = cur.start;
	assign token_out.token_length = cur.length;
	assign token_out.status       = cur.status;
	assign token_out.last_of_run  = last_now;

	// Record holding register.
	always_ff @(posedge clk) begin
		if (q_rd_en) begin
			rec_q <= q_rd_data;
		end
	end

	// Busy flag and token phase within the record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (q_rd_en) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (fire) begin
			if (last_now) begin
				busy_q  <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/keyword_lexer_stream_core.sv -----
// Keyword lexer top level: front end, record queue and back end.
//
// Usage: text_in carries one beat per text byte (kind 0) and an end beat (kind 1)
// to close a text. token_out carries the tokens: punctuation, words and the
// keywords if, loop, break and continue, each with start and length, then an
// EOF token for the end beat. last_of_run marks the final token of one input beat.
// cfg_wr_en with cfg_wr_data sets the token capacity; write it only while idle.
// Throughput: one input beat per cycle while the record queue is not full.
// Each byte is decided when the next beat arrives, so its token appears one
// input beat later. An end beat can give two tokens, sent as two output beats.
// A token is written into the record queue when the beat that causes it is
// accepted, and reaches token_out through the back end holding register.
// Reset clears the text state and the queue and sets the capacity to 4096.
// When the receiver stalls, the back end holds its beat, the four-entry record
// queue fills, and text_in.ready falls once the queue is full.
`default_nettype none
module keyword_lexer_stream_core #(
	parameter int MAX_TEXT      = kls_pkg::MAX_TEXT_DEF,
	parameter int KEYWORD_BYTES = kls_pkg::KEYWORD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	kls_in_if.sink           text_in,
	kls_out_if.source        token_out
);
	import kls_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_wr_en;
	logic q_rd_en;
	rec_t q_wr_data;
	rec_t q_rd_data;

	// Front end: lexer state and token formation.
	kls_front #(
		.MAX_TEXT      (MAX_TEXT),
		.KEYWORD_BYTES (KEYWORD_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.text_in     (text_in),
		.q_full      (q_full),
		.q_wr_en     (q_wr_en),
		.q_wr_data   (q_wr_data)
	);

	// Record queue between the two ends.
	kls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// Back end: token beats to the receiver.
	kls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd_data (q_rd_data),
		.q_empty   (q_empty),
		.q_rd_en   (q_rd_en),
		.token_out (token_out)
	);

endmodule
`default_nettype wire

// ----- hdl/kls_checker.sv -----
// Port-level assertions on the token output of the keyword lexer, with their bind.
`default_nettype none
module kls_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [4:0]  token_kind,
	input wire logic [15:0] token_start,
	input wire logic [15:0] token_length,
	input wire logic [1:0]  status,
	input wire logic        last_of_run
);
	import kls_pkg::*;

	// A stalled beat stays offered with the same content.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length)
			&& $stable(status) && $stable(last_of_run))
		else $error("token beat changed while stalled");

	// An error beat carries the EOF code, no length, and closes its run.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> token_kind == TK_EOF && token_length == 16'd0
			&& last_of_run && (status == ST_FULL || status == ST_LONG))
		else $error("malformed error beat");

	// A full error reports start zero.
	a_full_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> token_start == 16'd0)
		else $error("full error with nonzero start");

	// Only a lexed token may be followed by more beats of the same run.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> token_kind != TK_EOF && status == ST_OK)
		else $error("EOF or error beat not last of its run");

endmodule

bind keyword_lexer_stream_core kls_checker u_kls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (token_out.valid),
	.out_ready    (token_out.ready),
	.token_kind   (token_out.token_kind),
	.token_start  (token_out.token_start),
	.token_length (token_out.token_length),
	.status       (token_out.status),
	.last_of_run  (token_out.last_of_run)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for keyword_lexer_stream_core: a token predictor checks every output beat.
`timescale 1ns / 100ps
module testbench;
	import kls_pkg::*;

	localparam int TEXT_LIMIT    = MAX_TEXT_DEF;
	localparam int LEN_CEILING   = 65535;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BEATS  = 900;
	localparam int REPORT_LIMIT  = 10;

	// Kinds of fragment that the random texts are built from.
	typedef enum int {
		PIECE_KEYWORD,
		PIECE_WORD,
		PIECE_PUNCT,
		PIECE_BLANK,
		PIECE_NOISE,
		PIECE_OTHER
	} piece_kind_t;

	// Output stall patterns.
	typedef enum int {
		RX_OPEN,
		RX_PERIODIC,
		RX_RANDOM,
		RX_STRETCH
	} rx_mode_t;

	// One expected token, in the shape of an output beat.
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  status;
		logic        last;
	} token_rec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	kls_in_if  text_in ();
	kls_out_if token_out ();

	keyword_lexer_stream_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.text_in     (text_in),
		.token_out   (token_out)
	);

	// Character sets used to build texts; punctuation is in token code order.
	string punct_chars = ",;:=+-*/<>(){}[]";
	string blank_chars = " \n\015\t";
	string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string other_chars = "0123456789#$!?.@~'\"";
	string keywords [4] = '{"if", "loop", "break", "continue"};

	// Predictor state.
	logic [15:0] capacity;
	logic [7:0]  lookahead_byte;
	bit          lookahead_full;
	int          text_pos;
	int          pend_len;
	int          tok_count;
	logic [7:0]  recent_window [8];
	bit          stopped;

	token_rec_t tokens_due [$];
	token_rec_t beat_tokens [$];

	int fail_count;
	int live_beats;
	bit gaps_on;
	int burst_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2000000;
		$display("** keyword_lexer_stream_core: FAILED **");
		$finish;
	end

	// Clears everything that belongs to one text.
	function automatic void clear_text();
		lookahead_byte = 8'h00;
		lookahead_full = 1'b0;
		text_pos = 0;
		pend_len = 0;
		tok_count = 0;
		stopped = 1'b0;
		for (int i = 0; i < 8; i++)
			recent_window[i] = 8'h00;
	endfunction

	function automatic bit is_word_char(input logic [7:0] c);
		return (c == "_") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		for (int i = 0; i < blank_chars.len(); i++)
			if (c == blank_chars[i])
				return 1'b1;
		return 1'b0;
	endfunction

	// Punctuation codes run from the comma upwards in the order of punct_chars.
	function automatic logic [4:0] punct_token(input logic [7:0] c);
		for (int i = 0; i < punct_chars.len(); i++)
			if (c == punct_chars[i])
				return 5'(TK_COMMA + i);
		return TK_EOF;
	endfunction

	// A keyword matches only when the whole pending word is exactly that keyword.
	function automatic bit keyword_at(input string kw);
		int n;
		n = kw.len();
		if (pend_len != n)
			return 1'b0;
		for (int k = 0; k < n; k++)
			if (recent_window[n - 1 - k] != kw[k])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [4:0] word_token();
		if (keyword_at("if"))
			return TK_IF;
		if (keyword_at("loop"))
			return TK_LOOP;
		if (keyword_at("break"))
			return TK_BREAK;
		if (keyword_at("continue"))
			return TK_CONTINUE;
		return TK_WORD;
	endfunction

	function automatic void record_token(input logic [4:0] k, input int start, input int len,
			input logic [1:0] st);
		token_rec_t t;
		t.kind = k;
		t.start = 16'(start);
		t.length = 16'(len);
		t.status = st;
		t.last = 1'b0;
		beat_tokens.push_back(t);
	endfunction

	// Emits a token with the pending length, or the full error; returns 0 on the error.
	function automatic bit emit_token(input logic [4:0] k, input int start);
		int len;
		len = pend_len;
		pend_len = 0;
		if (tok_count >= int'(capacity)) begin
			record_token(TK_EOF, 0, 0, ST_FULL);
			stopped = 1'b1;
			return 1'b0;
		end
		tok_count++;
		record_token(k, start, len, ST_OK);
		return 1'b1;
	endfunction

	// Decides the held byte with the next byte, or with none at the end of a text.
	function automatic bit decide_held(input bit at_end, input logic [7:0] next);
		logic [7:0] c;
		logic [4:0] code;
		c = lookahead_byte;
		lookahead_full = 1'b0;
		if (pend_len < LEN_CEILING)
			pend_len++;
		for (int i = 7; i > 0; i--)
			recent_window[i] = recent_window[i - 1];
		recent_window[0] = c;
		if (is_word_char(c) && (at_end || !is_word_char(next)))
			return emit_token(word_token(), text_pos - pend_len);
		if (is_blank(c) && (at_end || !is_blank(next))) begin
			pend_len = 0;
			return 1'b1;
		end
		code = punct_token(c);
		if (code != TK_EOF)
			return emit_token(code, text_pos - 1);
		return 1'b1;
	endfunction

	// Works out the tokens that one accepted beat causes and queues them.
	function automatic void lex_beat(input logic k, input logic [7:0] b);
		bit ok;
		token_rec_t t;
		beat_tokens.delete();
		if (k == KIND_END) begin
			if (!stopped) begin
				ok = 1'b1;
				if (lookahead_full)
					ok = decide_held(1'b1, 8'h00);
				if (ok)
					void'(emit_token(TK_EOF, text_pos));
			end
			clear_text();
		end else if (!stopped) begin
			if (text_pos >= TEXT_LIMIT) begin
				record_token(TK_EOF, text_pos, 0, ST_LONG);
				stopped = 1'b1;
			end else begin
				ok = 1'b1;
				if (lookahead_full)
					ok = decide_held(1'b0, b);
				if (ok) begin
					lookahead_byte = b;
					lookahead_full = 1'b1;
					text_pos++;
				end
			end
		end
		foreach (beat_tokens[i]) begin
			t = beat_tokens[i];
			t.last = (i == beat_tokens.size() - 1);
			tokens_due.push_back(t);
		end
	endfunction

	// Sends one beat, with a random gap between bursts, and predicts it once accepted.
	task automatic send_beat(input logic k, input logic [7:0] b);
		if (gaps_on) begin
			if (burst_left == 0) begin
				text_in.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
			end
			burst_left--;
		end
		text_in.valid <= 1'b1;
		text_in.kind <= k;
		text_in.byte_value <= b;
		do
			@(posedge clk);
		while (!text_in.ready);
		live_beats++;
		lex_beat(k, b);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(KIND_BYTE, s[i]);
	endtask

	task automatic send_end();
		send_beat(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// Waits until every expected token has arrived and the pipeline has settled.
	task automatic wait_drained();
		text_in.valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity = value;
	endtask

	// Keywords, a long word, whitespace of every kind and the byte extremes.
	task automatic test_keywords();
		send_string("if loop\tbreak;continues");
		send_beat(KIND_BYTE, 8'h00);
		send_beat(KIND_BYTE, 8'hFF);
		send_string("\015\n");
		send_end();
		// An empty text gives only its EOF token.
		send_end();
	endtask

	// Full token list, on a byte and on the end beat, at capacities 0 and 1; then a text at 16'hFFFF.
	task automatic test_capacity_limits();
		write_capacity(16'd0);
		send_string("a");
		send_end();
		send_string("(xy");
		send_end();
		write_capacity(16'd1);
		send_string("ab");
		send_end();
		send_string("++");
		send_end();
		write_capacity(16'hFFFF);
		send_string("loop{}");
		send_end();
		write_capacity(CAP_RESET);
	endtask

	// One random text built mostly from well-formed fragments, usually closed by an end beat.
	task automatic send_random_text();
		int pieces;
		int n;
		piece_kind_t piece;
		pieces = $urandom_range(0, 12);
		for (int i = 0; i < pieces; i++) begin
			piece = piece_kind_t'($urandom_range(0, 5));
			case (piece)
				PIECE_KEYWORD: send_string(keywords[$urandom_range(0, 3)]);
				PIECE_WORD: begin
					n = $urandom_range(1, 10);
					for (int j = 0; j < n; j++)
						send_beat(KIND_BYTE, word_chars[$urandom_range(0, word_chars.len() - 1)]);
				end
				PIECE_PUNCT: send_beat(KIND_BYTE, punct_chars[$urandom_range(0, 15)]);
				PIECE_BLANK: begin
					n = $urandom_range(1, 3);
					for (int j = 0; j < n; j++)
						send_beat(KIND_BYTE, blank_chars[$urandom_range(0, 3)]);
				end
				PIECE_NOISE: send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
				default: send_beat(KIND_BYTE,
					other_chars[$urandom_range(0, other_chars.len() - 1)]);
			endcase
		end
		if ($urandom_range(0, 9) != 0)
			send_end();
	endtask

	// Random texts under several capacity settings.
	task automatic test_random_texts();
		logic [15:0] caps [5];
		int target;
		caps[0] = 16'hFFFF;
		caps[1] = 16'($urandom_range(1, 4));
		caps[2] = 16'd0;
		caps[3] = CAP_RESET;
		caps[4] = 16'($urandom_range(0, 65535));
		for (int ph = 0; ph < 5; ph++) begin
			write_capacity(caps[ph]);
			target = live_beats + RANDOM_BEATS / 5;
			while (live_beats < target)
				send_random_text();
		end
		send_end();
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("mismatch %0d: %s", fail_count, msg);
	endtask

	// Output side: stalls follow a pattern that changes at random intervals.
	initial begin
		rx_mode_t stall_mode;
		int stall_left;
		int stall_tick;
		stall_mode = RX_OPEN;
		stall_left = 0;
		stall_tick = 0;
		token_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(32, 400);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				RX_OPEN: token_out.ready <= 1'b1;
				RX_PERIODIC: token_out.ready <= (stall_tick % 4) != 0;
				RX_RANDOM: token_out.ready <= ($urandom_range(0, 3) != 0);
				default: token_out.ready <= ((stall_tick / 8) % 2) == 0;
			endcase
		end
	end

	// Each output beat is compared with the oldest expected token.
	always @(posedge clk) begin
		token_rec_t got;
		token_rec_t want;
		if (arst_n && token_out.valid && token_out.ready) begin
			got.kind = token_out.token_kind;
			got.start = token_out.token_start;
			got.length = token_out.token_length;
			got.status = token_out.status;
			got.last = token_out.last_of_run;
			if (tokens_due.size() == 0) begin
				note_failure($sformatf("unexpected token kind %0d start %0d length %0d",
					got.kind, got.start, got.length));
			end else begin
				want = tokens_due.pop_front();
				if (got !== want)
					note_failure($sformatf(
						"kind %0d/%0d start %0d/%0d length %0d/%0d status %0d/%0d last %0d/%0d",
						want.kind, got.kind, want.start, got.start, want.length, got.length,
						want.status, got.status, want.last, got.last));
			end
		end
	end

	// Main sequence: reset, the tests in turn, then drain and report.
	initial begin
		fail_count = 0;
		live_beats = 0;
		gaps_on = 1'b1;
		burst_left = 0;
		capacity = CAP_RESET;
		clear_text();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 16'h0000;
		text_in.valid <= 1'b0;
		text_in.kind <= KIND_BYTE;
		text_in.byte_value <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_keywords();
		test_capacity_limits();
		test_random_texts();

		wait_drained();
		if (fail_count == 0 && tokens_due.size() == 0)
			$display("** keyword_lexer_stream_core: PASSED **");
		else
			$display("** keyword_lexer_stream_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/kls_pkg.sv
hdl/kls_if.sv
hdl/kls_front.sv
hdl/kls_queue.sv
hdl/kls_back.sv
hdl/keyword_lexer_stream_core.sv
hdl/kls_checker.sv
tb/sv/testbench.sv
